// File: rtl/triangle_pressure_gradient_force_assert.svh
// Assertion macros for the triangle pressure gradient force block.
// Needs a clock i_clk and active-low reset i_rst_n in the including module.
`ifndef TRIANGLE_PRESSURE_GRADIENT_FORCE_ASSERT_SVH
`define TRIANGLE_PRESSURE_GRADIENT_FORCE_ASSERT_SVH

// same-cycle implication
`define TPGF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tpgf assertion failed");

// next-cycle implication
`define TPGF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tpgf assertion failed");

`endif

// File: rtl/tpgf_pkg.sv
// Shared types and constants for the triangle pressure gradient force block.
// No dependencies.
`default_nettype none
package tpgf_pkg;
    localparam int unsigned QBITS = 48;
    localparam logic [31:0] MIN_DEPTH_RST = 32'd66;
    localparam logic [14:0] HS_SCALE = 15'd25600;
    localparam logic REG_MIN_DEPTH = 1'b0;
    localparam logic [47:0] POS_LIMIT = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] NEG_LIMIT = 48'h8000_0000_0000;

    typedef struct packed {
        logic negx;
        logic negy;
        logic bigx;
        logic bigy;
        logic degen;
        logic last;
    } t_side;
endpackage
`default_nettype wire

// File: rtl/triangle_pressure_gradient_force.sv
// Accepts one triangle per cycle while the output is not stalled.
// Depth set by the 48-stage restoring divider, one quotient bit per stage per force.
// Reset (synchronous, active low) empties the pipeline and sets min_depth to 66.
// A stalled output freezes the whole pipeline.
// Top level: pipelined triangle pressure gradient forcing. Uses tpgf_pkg and
// triangle_pressure_gradient_force_assert.svh.
`default_nettype none
`include "triangle_pressure_gradient_force_assert.svh"
module triangle_pressure_gradient_force
    import tpgf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_corner_a_x,
    input  wire logic signed [31:0] i_corner_a_y,
    input  wire logic signed [31:0] i_corner_b_x,
    input  wire logic signed [31:0] i_corner_b_y,
    input  wire logic signed [31:0] i_corner_c_x,
    input  wire logic signed [31:0] i_corner_c_y,
    input  wire logic [31:0]        i_pressure_a,
    input  wire logic [31:0]        i_pressure_b,
    input  wire logic [31:0]        i_pressure_c,
    input  wire logic signed [31:0] i_surface_level,
    input  wire logic signed [31:0] i_bed_level,
    input  wire logic               i_last_triangle,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [47:0]      o_force_x,
    output logic signed [47:0]      o_force_y,
    output logic                    o_degenerate,
    output logic                    o_saturated,
    output logic                    o_last_result
);
    logic [31:0] r_min_depth;
    logic adv;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MIN_DEPTH) ? r_min_depth : 32'd0;
    assign adv = !o_valid || !i_stall;
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_depth <= MIN_DEPTH_RST;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_MIN_DEPTH) begin
            r_min_depth <= pwdata;
        end
    end

    // stage 1: differences, depth clamp
    logic signed [32:0] r1_dx1, r1_dy1, r1_dx2, r1_dy2, r1_dq1, r1_dq2;
    logic [31:0] r1_h;
    logic r1_last, r1_v;
    logic signed [32:0] depth;
    assign depth = $signed({i_surface_level[31], i_surface_level})
                 - $signed({i_bed_level[31], i_bed_level});

    // stage 2: products
    logic signed [65:0] r2_m [0:5];
    logic [46:0] r2_hs;
    logic r2_last, r2_v;

    // stage 3: determinant and numerators
    logic signed [66:0] r3_d, r3_nx, r3_ny;
    logic [46:0] r3_hs;
    logic r3_last, r3_v;

    // stage 4: magnitudes
    logic [65:0] r4_dm, r4_nxm, r4_nym;
    logic r4_sd, r4_snx, r4_sny, r4_degen;
    logic [46:0] r4_hs;
    logic r4_last, r4_v;

    // stage 5: partial products, scaled divisor
    logic [68:0] r5_px [0:2];
    logic [68:0] r5_py [0:2];
    logic [75:0] r5_den;
    t_side r5_side;
    logic r5_v;

    // stage 6: numerators
    logic [112:0] r6_numx, r6_numy;
    logic [75:0] r6_den;
    t_side r6_side;
    logic r6_v;

    // side flags entering the divider, with the overflow checks folded in
    t_side side0;

    // divider lanes, index 0 is the overflow check stage
    logic [112:0] r_rx [0:QBITS];
    logic [112:0] r_ry [0:QBITS];
    logic [47:0]  r_qx [0:QBITS];
    logic [47:0]  r_qy [0:QBITS];
    logic [75:0]  r_den [0:QBITS];
    t_side        r_side [0:QBITS];
    logic         r_vd [0:QBITS];

    // quotient of 2^48 or more saturates unless the triangle is degenerate
    always_comb begin
        side0 = r6_side;
        side0.bigx = {11'b0, r6_numx} >= {r6_den, 48'b0};
        side0.bigy = {11'b0, r6_numy} >= {r6_den, 48'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r_vd[0] <= 1'b0;
        end else if (adv) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r_vd[0] <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_dx1 <= $signed({i_corner_b_x[31], i_corner_b_x})
                    - $signed({i_corner_a_x[31], i_corner_a_x});
            r1_dy1 <= $signed({i_corner_b_y[31], i_corner_b_y})
                    - $signed({i_corner_a_y[31], i_corner_a_y});
            r1_dx2 <= $signed({i_corner_c_x[31], i_corner_c_x})
                    - $signed({i_corner_a_x[31], i_corner_a_x});
            r1_dy2 <= $signed({i_corner_c_y[31], i_corner_c_y})
                    - $signed({i_corner_a_y[31], i_corner_a_y});
            r1_dq1 <= $signed({1'b0, i_pressure_b}) - $signed({1'b0, i_pressure_a});
            r1_dq2 <= $signed({1'b0, i_pressure_c}) - $signed({1'b0, i_pressure_a});
            r1_h <= (depth < $signed({1'b0, r_min_depth})) ? r_min_depth : depth[31:0];
            r1_last <= i_last_triangle;

            r2_m[0] <= r1_dy2 * r1_dx1;
            r2_m[1] <= r1_dy1 * r1_dx2;
            r2_m[2] <= r1_dy2 * r1_dq1;
            r2_m[3] <= r1_dy1 * r1_dq2;
            r2_m[4] <= r1_dx1 * r1_dq2;
            r2_m[5] <= r1_dx2 * r1_dq1;
            r2_hs <= 47'(r1_h) * 47'(HS_SCALE);
            r2_last <= r1_last;

            r3_d  <= 67'(r2_m[0]) - 67'(r2_m[1]);
            r3_nx <= 67'(r2_m[2]) - 67'(r2_m[3]);
            r3_ny <= 67'(r2_m[4]) - 67'(r2_m[5]);
            r3_hs <= r2_hs;
            r3_last <= r2_last;

            r4_dm  <= r3_d[66]  ? 66'(-r3_d)  : r3_d[65:0];
            r4_nxm <= r3_nx[66] ? 66'(-r3_nx) : r3_nx[65:0];
            r4_nym <= r3_ny[66] ? 66'(-r3_ny) : r3_ny[65:0];
            r4_sd  <= r3_d[66];
            r4_snx <= r3_nx[66];
            r4_sny <= r3_ny[66];
            r4_degen <= (r3_d == 67'sd0);
            r4_hs <= r3_hs;
            r4_last <= r3_last;

            for (int i = 0; i < 3; i++) begin
                r5_px[i] <= 69'(r4_hs) * 69'(r4_nxm[22*i +: 22]);
                r5_py[i] <= 69'(r4_hs) * 69'(r4_nym[22*i +: 22]);
            end
            r5_den <= {r4_dm, 10'b0} - 76'(r4_dm);
            r5_side.negx  <= (r4_snx == r4_sd) && (r4_nxm != 66'd0) && (r4_hs != 47'd0);
            r5_side.negy  <= (r4_sny == r4_sd) && (r4_nym != 66'd0) && (r4_hs != 47'd0);
            r5_side.bigx  <= 1'b0;
            r5_side.bigy  <= 1'b0;
            r5_side.degen <= r4_degen;
            r5_side.last  <= r4_last;

            r6_numx <= 113'(r5_px[0]) + (113'(r5_px[1]) << 22) + (113'(r5_px[2]) << 44);
            r6_numy <= 113'(r5_py[0]) + (113'(r5_py[1]) << 22) + (113'(r5_py[2]) << 44);
            r6_den <= r5_den;
            r6_side <= r5_side;

            r_rx[0] <= r6_numx;
            r_ry[0] <= r6_numy;
            r_qx[0] <= '0;
            r_qy[0] <= '0;
            r_den[0] <= r6_den;
            r_side[0] <= side0;
        end
    end

    genvar s;
    generate
        for (s = 0; s < QBITS; s++) begin : g_div
            localparam int K = QBITS - 1 - s;
            logic [123:0] sh;
            logic gex, gey;
            assign sh  = 124'(r_den[s]) << K;
            assign gex = 124'(r_rx[s]) >= sh;
            assign gey = 124'(r_ry[s]) >= sh;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vd[s+1] <= 1'b0;
                end else if (adv) begin
                    r_vd[s+1] <= r_vd[s];
                end
            end

            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_rx[s+1] <= gex ? 113'(124'(r_rx[s]) - sh) : r_rx[s];
                    r_ry[s+1] <= gey ? 113'(124'(r_ry[s]) - sh) : r_ry[s];
                    r_qx[s+1] <= r_qx[s] | (48'(gex) << K);
                    r_qy[s+1] <= r_qy[s] | (48'(gey) << K);
                    r_den[s+1] <= r_den[s];
                    r_side[s+1] <= r_side[s];
                end
            end
        end
    endgenerate

    // output stage: saturation and sign
    t_side fs;
    logic [47:0] limx, limy, magx, magy;
    logic satx, saty;
    assign fs = r_side[QBITS];
    assign limx = fs.negx ? NEG_LIMIT : POS_LIMIT;
    assign limy = fs.negy ? NEG_LIMIT : POS_LIMIT;
    assign satx = fs.bigx || (r_qx[QBITS] > limx);
    assign saty = fs.bigy || (r_qy[QBITS] > limy);
    assign magx = satx ? limx : r_qx[QBITS];
    assign magy = saty ? limy : r_qy[QBITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (adv) begin
            o_valid <= r_vd[QBITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (fs.degen) begin
                o_force_x <= '0;
                o_force_y <= '0;
                o_saturated <= 1'b0;
            end else begin
                o_force_x <= fs.negx ? -$signed(magx) : $signed(magx);
                o_force_y <= fs.negy ? -$signed(magy) : $signed(magy);
                o_saturated <= satx || saty;
            end
            o_degenerate <= fs.degen;
            o_last_result <= fs.last;
        end
    end

    `TPGF_ASSERT_NOW(a_degen_zero, o_valid && o_degenerate,
        o_force_x == 48'sd0 && o_force_y == 48'sd0 && !o_saturated)
    `TPGF_ASSERT_NOW(a_stall_only_when_held, o_stall, o_valid && i_stall)
    `TPGF_ASSERT_NEXT(a_freeze_div, !adv, $stable(r_vd[QBITS]) && $stable(r_qx[QBITS]))
    `TPGF_ASSERT_NEXT(a_freeze_out, o_valid && i_stall, o_valid && $stable(o_force_x))
endmodule
`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for triangle_pressure_gradient_force: random and directed triangles,
// predicted in wide integer arithmetic and compared field by field at the output.
// Depends on tpgf_pkg and the RTL top level; needs no files or arguments.
module testbench;
    import tpgf_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 80;
    localparam int LONG_HOLD = 250;
    localparam logic [2:0] ADDR_MIN_DEPTH = 3'(4 * REG_MIN_DEPTH);
    localparam logic [2:0] ADDR_UNMAPPED = 3'(4 * (REG_MIN_DEPTH + 1));
    localparam int KIND_FULL = 0;
    localparam int KIND_SMALL = 1;
    localparam int KIND_FLAT = 2;
    localparam int KIND_EXTREME = 3;

    typedef struct {
        logic signed [31:0] ax, ay, bx, by, cx, cy;
        logic [31:0]        pa, pb, pc;
        logic signed [31:0] sl, bl;
        logic               last;
    } tri_t;

    typedef struct {
        logic signed [47:0] fx, fy;
        logic               degen, sat, last;
    } force_t;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_valid = 0;
    logic o_stall;
    tri_t cur = '{default: '0};
    logic o_valid;
    logic i_stall = 0;
    logic signed [47:0] o_force_x, o_force_y;
    logic o_degenerate, o_saturated, o_last_result;

    tri_t   pending_tris[$];
    force_t expected_forces[$];
    logic [31:0] depth_floor = MIN_DEPTH_RST;
    bit idle_on = 1;
    bit hold_req = 0;
    int gap_cnt = 0, hold_cnt = 0, cycles = 0, errors = 0;

    triangle_pressure_gradient_force dut (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .i_valid, .o_stall,
        .i_corner_a_x(cur.ax), .i_corner_a_y(cur.ay),
        .i_corner_b_x(cur.bx), .i_corner_b_y(cur.by),
        .i_corner_c_x(cur.cx), .i_corner_c_y(cur.cy),
        .i_pressure_a(cur.pa), .i_pressure_b(cur.pb), .i_pressure_c(cur.pc),
        .i_surface_level(cur.sl), .i_bed_level(cur.bl), .i_last_triangle(cur.last),
        .o_valid, .i_stall, .o_force_x, .o_force_y, .o_degenerate, .o_saturated,
        .o_last_result
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [47:0] scaled_quotient(logic signed [191:0] num,
                                                    logic signed [191:0] den,
                                                    inout logic sat);
        logic neg;
        logic [191:0] mn, mdn, q, lim;
        neg = (num[191] == den[191]) && (num != 0);
        mn = num[191] ? -num : num;
        mdn = den[191] ? -den : den;
        q = mn / mdn;
        lim = neg ? 192'(NEG_LIMIT) : 192'(POS_LIMIT);
        if (q > lim) begin
            q = lim;
            sat = 1;
        end
        return neg ? 48'(-q) : 48'(q);
    endfunction

    function automatic force_t gradient_force(tri_t t, logic [31:0] floor_depth);
        logic signed [191:0] dx1, dy1, dx2, dy2, dq1, dq2, det, nx, ny, h;
        force_t r;
        logic sat;
        sat = 0;
        dx1 = $signed(t.bx) - $signed(t.ax);
        dy1 = $signed(t.by) - $signed(t.ay);
        dx2 = $signed(t.cx) - $signed(t.ax);
        dy2 = $signed(t.cy) - $signed(t.ay);
        dq1 = $signed({1'b0, t.pb}) - $signed({1'b0, t.pa});
        dq2 = $signed({1'b0, t.pc}) - $signed({1'b0, t.pa});
        det = dy2 * dx1 - dy1 * dx2;
        r.last = t.last;
        if (det == 0) begin
            r.fx = 0;
            r.fy = 0;
            r.degen = 1;
            r.sat = 0;
            return r;
        end
        nx = dy2 * dq1 - dy1 * dq2;
        ny = dx1 * dq2 - dx2 * dq1;
        h = $signed(t.sl) - $signed(t.bl);
        if (h < $signed({1'b0, floor_depth})) h = {160'b0, floor_depth};
        r.fx = scaled_quotient(h * 25600 * nx, 1023 * det, sat);
        r.fy = scaled_quotient(h * 25600 * ny, 1023 * det, sat);
        r.degen = 0;
        r.sat = sat;
        return r;
    endfunction

    function automatic logic [31:0] edge_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            4: return 32'h1;
            default: return $urandom;
        endcase
    endfunction

    function automatic tri_t make_tri(int kind);
        tri_t t;
        int dx, dy, k;
        logic [31:0] p0;
        t.last = ($urandom_range(0, 9) == 0);
        case (kind)
            KIND_FULL: begin
                t.ax = $urandom; t.ay = $urandom; t.bx = $urandom; t.by = $urandom;
                t.cx = $urandom; t.cy = $urandom; t.pa = $urandom; t.pb = $urandom;
                t.pc = $urandom; t.sl = $urandom; t.bl = $urandom;
            end
            KIND_EXTREME: begin
                t.ax = edge_value(); t.ay = edge_value(); t.bx = edge_value();
                t.by = edge_value(); t.cx = edge_value(); t.cy = edge_value();
                t.pa = edge_value(); t.pb = edge_value(); t.pc = edge_value();
                t.sl = edge_value(); t.bl = edge_value();
            end
            default: begin
                t.ax = $signed($urandom) >>> $urandom_range(1, 8);
                t.ay = $signed($urandom) >>> $urandom_range(1, 8);
                dx = int'($urandom_range(0, 4000)) - 2000;
                dy = int'($urandom_range(0, 4000)) - 2000;
                t.bx = t.ax + dx;
                t.by = t.ay + dy;
                if (kind == KIND_FLAT) begin
                    k = int'($urandom_range(0, 8)) - 4;
                    t.cx = t.ax + k * dx;
                    t.cy = t.ay + k * dy;
                end else begin
                    t.cx = t.ax + int'($urandom_range(0, 4000)) - 2000;
                    t.cy = t.ay + int'($urandom_range(0, 4000)) - 2000;
                end
                p0 = 32'd66000000 + $urandom_range(0, 1000000);
                t.pa = ($urandom_range(0, 7) == 0) ? 32'h0 : p0 + $urandom_range(0, 50000);
                t.pb = ($urandom_range(0, 7) == 0) ? 32'h0 : p0 + $urandom_range(0, 50000);
                t.pc = ($urandom_range(0, 7) == 0) ? 32'h0 : p0 + $urandom_range(0, 50000);
                t.bl = int'($urandom_range(0, 2000000)) - 1000000;
                t.sl = t.bl + int'($urandom_range(0, 3000000)) - 500000;
            end
        endcase
        return t;
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
        end else begin
            if (i_valid && !o_stall) expected_forces.push_back(gradient_force(cur, depth_floor));
            if (!i_valid || !o_stall) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                    i_valid <= 0;
                end else if (pending_tris.size() > 0) begin
                    cur <= pending_tris.pop_front();
                    i_valid <= 1;
                    if (idle_on && $urandom_range(0, 7) == 0) gap_cnt = $urandom_range(1, 6);
                end else begin
                    i_valid <= 0;
                end
            end
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_cnt = LONG_HOLD;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_stall <= 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            hold_cnt = $urandom_range(0, 5);
            i_stall <= 1;
        end else begin
            i_stall <= 0;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        force_t e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_forces.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result transfer");
            end else begin
                e = expected_forces.pop_front();
                if (e.fx !== o_force_x || e.fy !== o_force_y || e.degen !== o_degenerate
                        || e.sat !== o_saturated || e.last !== o_last_result) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp fx=%0d fy=%0d dg=%b st=%b lr=%b",
                                 e.fx, e.fy, e.degen, e.sat, e.last,
                                 " got fx=%0d fy=%0d dg=%b st=%b lr=%b",
                                 o_force_x, o_force_y, o_degenerate, o_saturated,
                                 o_last_result);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("triangle_pressure_gradient_force regression: fail");
            $finish;
        end
    end

    task automatic apb_write(logic [2:0] a, logic [31:0] d);
        psel <= 1; pwrite <= 1; penable <= 0; paddr <= a; pwdata <= d;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (a == ADDR_MIN_DEPTH) depth_floor = d;
    endtask

    task automatic drain();
        while (pending_tris.size() > 0 || i_valid || expected_forces.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        tri_t t;
        logic [31:0] floors[5];
        floors = '{MIN_DEPTH_RST, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0001_0000};
        floors[3] = $urandom;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: flat, extreme and deep/dry triangles
        t = '{default: '0};
        pending_tris.push_back(t);
        t = '{ax: 32'sh8000_0000, ay: 32'sh8000_0000, bx: 32'sh7FFF_FFFF, by: 32'sh8000_0000,
              cx: 32'sh8000_0000, cy: 32'sh7FFF_FFFF, pa: 0, pb: 32'hFFFF_FFFF,
              pc: 32'hFFFF_FFFF, sl: 32'sh7FFF_FFFF, bl: 32'sh8000_0000, last: 1};
        pending_tris.push_back(t);
        t.pa = 32'hFFFF_FFFF; t.pb = 0; t.pc = 0; t.sl = 32'sh8000_0000; t.bl = 32'sh7FFF_FFFF;
        pending_tris.push_back(t);
        t = '{ax: 0, ay: 0, bx: 256, by: 0, cx: 0, cy: 256, pa: 0, pb: 65536, pc: 0,
              sl: 0, bl: 65536, last: 0};
        pending_tris.push_back(t);
        t.pb = 0; t.pc = 65536; t.sl = 65536 * 10; t.bl = 0;
        pending_tris.push_back(t);
        t.bx = 1; t.cy = 1; t.pb = 32'hFFFF_FFFF; t.pc = 32'hFFFF_FFFF;
        pending_tris.push_back(t);
        for (int i = 0; i < 6; i++) pending_tris.push_back(make_tri(KIND_FLAT));
        for (int i = 0; i < 12; i++) pending_tris.push_back(make_tri(KIND_EXTREME));
        for (int ph = 0; ph < 5; ph++) begin
            if (ph == 3) apb_write(ADDR_UNMAPPED, $urandom);
            if (ph > 0) apb_write(ADDR_MIN_DEPTH, floors[ph]);
            idle_on = (ph != 4);
            for (int i = 0; i < 126; i++) begin
                case ($urandom_range(0, 9))
                    0, 1: pending_tris.push_back(make_tri(KIND_FULL));
                    2: pending_tris.push_back(make_tri(KIND_FLAT));
                    3: pending_tris.push_back(make_tri(KIND_EXTREME));
                    default: pending_tris.push_back(make_tri(KIND_SMALL));
                endcase
            end
            if (ph == 1) begin
                @(posedge i_clk);
                hold_req = 1;
            end
            drain();
        end
        if (errors == 0)
            $display("triangle_pressure_gradient_force regression: pass");
        else
            $display("triangle_pressure_gradient_force regression: fail");
        $finish;
    end
endmodule
